FILE: rtl/cnrf_pkg.sv
`default_nettype none
package cnrf_pkg;

  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned FRAC_BITS  = 24;
  localparam int unsigned TOL_BITS   = 25;
  localparam int unsigned LIMIT_BITS = 8;
  localparam int unsigned IDX_BITS   = 3;
  localparam int unsigned STAT_BITS  = 2;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [TOL_BITS-1:0]   tol_t;
  typedef logic [LIMIT_BITS-1:0] count_t;
  typedef logic [IDX_BITS-1:0]   cfg_idx_t;
  typedef logic [STAT_BITS-1:0]  status_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam word_t  SQUARE_RESET = 32'h0166_6666;  // 1.4
  localparam word_t  CONST_RESET  = 32'hFD19_999A;  // -2.9
  localparam tol_t   TOL_RESET    = 25'd17;
  localparam count_t LIMIT_RESET  = 8'd100;
  localparam tol_t   FLOOR_RESET  = 25'd1;

  localparam cfg_idx_t CFG_SQUARE = 3'd0;
  localparam cfg_idx_t CFG_CONST  = 3'd1;
  localparam cfg_idx_t CFG_TOL    = 3'd2;
  localparam cfg_idx_t CFG_LIMIT  = 3'd3;
  localparam cfg_idx_t CFG_FLOOR  = 3'd4;

  localparam status_t ST_CONVERGED = 2'd0;
  localparam status_t ST_FLAT      = 2'd1;
  localparam status_t ST_LIMIT     = 2'd2;

  typedef struct packed {
    logic  start;
    word_t num;
    word_t den;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quo;
  } div_rsp_t;

  // magnitude of a two's complement word; the minimum maps to 2^(W-1)
  function automatic word_t mag(input word_t a);
    return a[WORD_BITS-1] ? (~a) + word_t'(1) : a;
  endfunction

  // rebuild a signed word from sign and magnitude, saturating
  function automatic word_t from_mag(input logic neg, input logic big, input word_t m);
    logic over;
    over = big | m[WORD_BITS-1];
    if (!neg) begin
      return over ? WORD_MAX : m;
    end
    return over ? WORD_MIN : (~m) + word_t'(1);
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b, input logic sub);
    logic [WORD_BITS:0] ea;
    logic [WORD_BITS:0] eb;
    logic [WORD_BITS:0] s;
    ea = {a[WORD_BITS-1], a};
    eb = {b[WORD_BITS-1], b};
    s  = sub ? ea - eb : ea + eb;
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WORD_MIN : WORD_MAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/cnrf_mul.sv
`default_nettype none
module cnrf_mul (
  input  logic           clk_i,
  input  cnrf_pkg::word_t a_i,
  input  cnrf_pkg::word_t b_i,
  output cnrf_pkg::word_t res_o
);
  import cnrf_pkg::*;

  localparam int unsigned PROD_BITS = 2 * WORD_BITS;

  logic [PROD_BITS-1:0] ma_w;
  logic [PROD_BITS-1:0] mb_w;
  logic [PROD_BITS-1:0] prod_q;
  logic                 neg_q;
  word_t                res_q;

  assign ma_w = PROD_BITS'(mag(a_i));
  assign mb_w = PROD_BITS'(mag(b_i));

  // stage one: exact magnitude product; stage two: truncate and saturate
  always_ff @(posedge clk_i) begin
    prod_q <= ma_w * mb_w;
    neg_q  <= a_i[WORD_BITS-1] ^ b_i[WORD_BITS-1];
    res_q  <= from_mag(neg_q, |prod_q[PROD_BITS-1:FRAC_BITS+WORD_BITS-1],
                       prod_q[FRAC_BITS+WORD_BITS-1:FRAC_BITS]);
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

FILE: rtl/cnrf_div.sv
`default_nettype none
module cnrf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cnrf_pkg::div_req_t req_i,
  output cnrf_pkg::div_rsp_t rsp_o
);
  import cnrf_pkg::*;

  localparam int unsigned HEAD_BITS = WORD_BITS - FRAC_BITS;
  localparam int unsigned STEP_BITS = $clog2(WORD_BITS);

  localparam logic [1:0] D_IDLE = 2'd0;
  localparam logic [1:0] D_RUN  = 2'd1;
  localparam logic [1:0] D_FIN  = 2'd2;

  logic [1:0]           dstate_q;
  logic [1:0]           dstate_d;
  logic                 done_q;
  logic [STEP_BITS-1:0] cnt_q;
  word_t                rem_q;
  word_t                md_q;
  word_t                low_q;
  word_t                quo_q;
  word_t                out_q;
  logic                 neg_q;
  logic                 big_q;

  word_t                mn_w;
  word_t                md_w;
  logic [WORD_BITS:0]   shifted_w;
  logic [WORD_BITS+1:0] diff_w;
  logic                 take_w;
  logic                 last_w;

  assign mn_w      = mag(req_i.num);
  assign md_w      = mag(req_i.den);
  assign shifted_w = {rem_q, low_q[WORD_BITS-1]};
  assign diff_w    = {1'b0, shifted_w} - {2'b00, md_q};
  assign take_w    = !diff_w[WORD_BITS+1];
  assign last_w    = (cnt_q == STEP_BITS'(WORD_BITS - 1));

  always_comb begin
    dstate_d = dstate_q;
    unique case (dstate_q)
      D_IDLE: begin
        if (req_i.start) begin
          if (md_w == '0 || (mn_w >> HEAD_BITS) >= md_w) begin
            dstate_d = D_FIN;
          end else begin
            dstate_d = D_RUN;
          end
        end
      end
      D_RUN: begin
        if (last_w) begin
          dstate_d = D_FIN;
        end
      end
      D_FIN:   dstate_d = D_IDLE;
      default: dstate_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dstate_q <= D_IDLE;
      done_q   <= 1'b0;
    end else begin
      dstate_q <= dstate_d;
      done_q   <= (dstate_q == D_FIN);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (dstate_q)
      D_IDLE: begin
        if (req_i.start) begin
          neg_q <= req_i.num[WORD_BITS-1] ^ req_i.den[WORD_BITS-1];
          md_q  <= md_w;
          quo_q <= '0;
          cnt_q <= '0;
          rem_q <= mn_w >> HEAD_BITS;
          low_q <= mn_w << FRAC_BITS;
          // zero divisor saturates unless the dividend is zero too
          if (md_w == '0) begin
            big_q <= (mn_w != '0);
          end else begin
            big_q <= ((mn_w >> HEAD_BITS) >= md_w);
          end
        end
      end
      D_RUN: begin
        rem_q <= take_w ? diff_w[WORD_BITS-1:0] : shifted_w[WORD_BITS-1:0];
        low_q <= low_q << 1;
        quo_q <= {quo_q[WORD_BITS-2:0], take_w};
        cnt_q <= cnt_q + STEP_BITS'(1);
      end
      D_FIN: begin
        out_q <= from_mag(neg_q, big_q, quo_q);
      end
      default: ;
    endcase
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = out_q;

endmodule
`default_nettype wire

FILE: rtl/cubic_newton_root_finder_top.sv
`default_nettype none
// channel   direction  handshake                        payload
// s_axis    in         s_axis_tvalid_i/s_axis_tready_o  tdata: start_point
// m_axis    out        m_axis_tvalid_o/m_axis_tready_i  tdata: root, iterations; tuser: status
// cfg       in         cfg_we_i (always taken)          cfg_index_i, cfg_data_i
//
// One item at a time: each Newton update issues four products to the multiplier, then
// 6 saturating adds, 1 check, a divide and 1 update test, plus accept, final evaluation
// and finish per item; at most 255 updates per item.
// Asynchronous active-low reset loads the default coefficients and limits.
// A new item is taken while the previous result still waits on m_axis; the
// sequencer holds in its finish state until the output register is free.
module cubic_newton_root_finder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [31:0]        s_axis_tdata_i,   // [31:0] start_point
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [39:0]        m_axis_tdata_o,   // [31:0] root, [39:32] iterations
  output logic [1:0]         m_axis_tuser_o,   // [1:0] status
  input  logic               cfg_we_i,
  input  cnrf_pkg::cfg_idx_t cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import cnrf_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_SUM   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam logic [2:0] LAST_STEP = 3'd5;

  // configuration
  word_t  c2_q;
  word_t  c0_q;
  tol_t   tol_q;
  count_t limit_q;
  tol_t   floor_q;

  // sequencer
  logic [2:0] state_q;
  logic [2:0] step_q;
  logic       chk_q;
  status_t    status_q;
  word_t      x_q;
  word_t      prev_q;
  count_t     count_q;

  // intermediates
  word_t x2_q;
  word_t cx_q;
  word_t x3_q;
  word_t cx2_q;
  word_t d_q;
  word_t p_q;

  // output register
  logic       out_valid_q;
  word_t      out_root_q;
  count_t     out_iter_q;
  status_t    out_stat_q;

  word_t    mul_a;
  word_t    mul_b;
  word_t    mul_res;
  word_t    add_a;
  word_t    add_b;
  logic     add_sub;
  word_t    add_res;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic s_accept;
  logic out_free;
  logic res_small;
  logic flat;
  logic step_small;

  assign s_accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign res_small  = mag(p_q) <= word_t'(tol_q);
  assign flat       = mag(d_q) < word_t'(floor_q);
  assign step_small = mag(add_res) <= word_t'(tol_q);

  cnrf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .res_o (mul_res)
  );

  assign div_req.start = (state_q == S_CHECK) && !(chk_q && res_small) && !flat;
  assign div_req.num   = p_q;
  assign div_req.den   = d_q;

  cnrf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // multiplier issue: x*x, c2*x, x2*x, c2*x2; results pass the product and result registers
  always_comb begin
    mul_a = x_q;
    mul_b = x_q;
    unique case (step_q)
      3'd1: mul_a = c2_q;
      3'd2: mul_a = mul_res;
      3'd3: begin
        mul_a = c2_q;
        mul_b = x2_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    add_a   = x_q;
    add_b   = prev_q;
    add_sub = 1'b1;
    unique case (state_q)
      S_SUM: begin
        add_sub = 1'b0;
        unique case (step_q)
          3'd0: begin add_a = x2_q; add_b = x2_q;  end
          3'd1: begin add_a = d_q;  add_b = x2_q;  end
          3'd2: begin add_a = cx_q; add_b = cx_q;  end
          3'd3: begin add_a = d_q;  add_b = p_q;   end
          3'd4: begin add_a = x3_q; add_b = cx2_q; end
          default: begin add_a = p_q; add_b = c0_q; end
        endcase
      end
      S_DIV:   add_b = div_rsp.quo;
      default: ;
    endcase
  end

  assign add_res = sat_add(add_a, add_b, add_sub);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_q        <= SQUARE_RESET;
      c0_q        <= CONST_RESET;
      tol_q       <= TOL_RESET;
      limit_q     <= LIMIT_RESET;
      floor_q     <= FLOOR_RESET;
      state_q     <= S_IDLE;
      step_q      <= '0;
      chk_q       <= 1'b0;
      status_q    <= ST_CONVERGED;
      x_q         <= '0;
      prev_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_SQUARE: c2_q    <= cfg_data_i;
          CFG_CONST:  c0_q    <= cfg_data_i;
          CFG_TOL:    tol_q   <= cfg_data_i[TOL_BITS-1:0];
          CFG_LIMIT:  limit_q <= cfg_data_i[LIMIT_BITS-1:0];
          CFG_FLOOR:  floor_q <= cfg_data_i[TOL_BITS-1:0];
          default: ;
        endcase
      end

      // a new result takes the output register over a drain in the same cycle
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_accept) begin
            x_q     <= s_axis_tdata_i;
            prev_q  <= s_axis_tdata_i;
            count_q <= '0;
            chk_q   <= 1'b0;
            step_q  <= '0;
            state_q <= S_EVAL;
          end
        end
        S_EVAL, S_SUM: begin
          if (step_q == LAST_STEP) begin
            step_q  <= '0;
            state_q <= (state_q == S_EVAL) ? S_SUM : S_CHECK;
          end else begin
            step_q <= step_q + 3'd1;
          end
        end
        S_CHECK: begin
          // residual test of the new estimate comes before the flat test
          if (chk_q && res_small) begin
            status_q <= ST_CONVERGED;
            state_q  <= S_FIN;
          end else if (flat) begin
            prev_q   <= x_q;
            status_q <= ST_FLAT;
            state_q  <= S_FIN;
          end else begin
            prev_q  <= x_q;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            x_q     <= add_res;
            count_q <= count_q + count_t'(1);
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          if (count_q >= limit_q) begin
            status_q <= ST_LIMIT;
            state_q  <= S_FIN;
          end else if (step_small) begin
            status_q <= ST_CONVERGED;
            state_q  <= S_FIN;
          end else begin
            chk_q   <= 1'b1;
            state_q <= S_EVAL;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EVAL) begin
      unique case (step_q)
        3'd2: x2_q  <= mul_res;
        3'd3: cx_q  <= mul_res;
        3'd4: x3_q  <= mul_res;
        3'd5: cx2_q <= mul_res;
        default: ;
      endcase
    end
    if (state_q == S_SUM) begin
      if (step_q == 3'd0 || step_q == 3'd1 || step_q == 3'd3) begin
        d_q <= add_res;
      end else begin
        p_q <= add_res;
      end
    end
    if (state_q == S_FIN && out_free) begin
      out_root_q <= x_q;
      out_iter_q <= count_q;
      out_stat_q <= status_q;
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_iter_q, out_root_q};
  assign m_axis_tuser_o  = out_stat_q;

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV)
    else $error("divider finished outside the divide state");

  a_accept_starts_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> (state_q == S_EVAL && step_q == 3'd0))
    else $error("accepted item did not start evaluation");

  a_update_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_UPD |-> count_q != '0)
    else $error("update state reached with zero update count");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o == ST_CONVERGED || m_axis_tuser_o == ST_FLAT ||
                         m_axis_tuser_o == ST_LIMIT))
    else $error("result carries an undefined status");

endmodule
`default_nettype wire

FILE: dv/tb_cubic_newton_root_finder_top.sv
module tb_cubic_newton_root_finder_top;
  import cnrf_pkg::*;

  typedef struct packed {
    word_t   root;
    count_t  iters;
    status_t status;
  } solution_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    cfg_idx_t  idx;
    word_t     value;
    logic      typed;
    solution_t want;
  } dir_row_t;

  localparam longint QMAX = 2147483647;
  localparam longint QMIN = -QMAX - 1;
  localparam word_t  ONE  = 32'h0100_0000;
  localparam solution_t NO_WANT = '0;

  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 22;
  localparam int STALL_CYCLES = 6000;
  localparam int MAX_SHOWN    = 10;
  localparam int N_DIR        = 36;

  // zero floor with zero coefficients: 0/0 gives no step; a nonzero constant over a zero
  // slope jumps to the negated maximum; limit 0 stops like limit 1
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{ROW_ITEM, '0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 8'd0, ST_FLAT}},
    '{ROW_ITEM, '0, 32'h0100_0000, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'hFF00_0000, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'h7FFF_FFFF, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'h8000_0000, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'h0000_0001, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'hFFFF_FFFF, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'hFF11_1111, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'h5555_5555, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'hAAAA_AAAA, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_FLOOR, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_SQUARE, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_CONST, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_LIMIT, 32'h0000_0001, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 8'd1, ST_LIMIT}},
    '{ROW_CFG, CFG_CONST, 32'h0100_0000, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'h0000_0000, 1'b1, '{32'h8000_0001, 8'd1, ST_LIMIT}},
    '{ROW_CFG, CFG_LIMIT, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'h0000_0000, 1'b1, '{32'h8000_0001, 8'd1, ST_LIMIT}},
    '{ROW_CFG, CFG_SQUARE, 32'h8000_0000, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_CONST, 32'h7FFF_FFFF, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_TOL, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_LIMIT, 32'h0000_00FF, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_FLOOR, 32'h0100_0000, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'h0100_0000, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'hF000_0000, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'h0000_0000, 1'b1, '{32'h0000_0000, 8'd0, ST_FLAT}},
    '{ROW_CFG, CFG_SQUARE, 32'h7FFF_FFFF, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_CONST, 32'h8000_0000, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_TOL, 32'h0100_0000, 1'b0, NO_WANT},
    '{ROW_CFG, CFG_FLOOR, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'h0200_0000, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'h8000_0000, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'h7FFF_FFFF, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'h0000_0000, 1'b0, NO_WANT},
    '{ROW_ITEM, '0, 32'h0000_1000, 1'b0, NO_WANT}
  };

  logic         clk_i;
  logic         rst_ni          = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  word_t        s_axis_tdata_i  = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [39:0]  m_axis_tdata_o;
  status_t      m_axis_tuser_o;
  logic         cfg_we_i        = 1'b0;
  cfg_idx_t     cfg_index_i     = CFG_SQUARE;
  word_t        cfg_data_i      = '0;

  // shadow copy of the register file
  longint sq_coef;
  longint const_coef;
  longint tol_lim;
  longint upd_limit;
  longint slope_min;

  solution_t pending_solutions[$];
  int        n_errors  = 0;
  int        n_results = 0;
  logic      held_off  = 1'b0;
  logic      src_calm  = 1'b0;

  cubic_newton_root_finder_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #500_000_000;
    $display("FAIL cubic_newton_root_finder_top");
    $finish;
  end

  function automatic longint clamp_w(input longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint abs_w(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // exact product, magnitude truncated by the fraction width, then saturated
  function automatic longint q_mul(input longint a, input longint b);
    longint p;
    p = (abs_w(a) * abs_w(b)) >>> FRAC_BITS;
    return clamp_w(((a < 0) != (b < 0)) ? -p : p);
  endfunction

  function automatic longint cubic_at(input longint x);
    longint x2;
    x2 = q_mul(x, x);
    return clamp_w(clamp_w(q_mul(x2, x) + q_mul(sq_coef, x2)) + const_coef);
  endfunction

  function automatic solution_t solve_cubic(input word_t start);
    longint    x;
    longint    prev;
    longint    x2;
    longint    cx;
    longint    d;
    longint    num;
    longint    quo;
    int        count;
    status_t   st;
    solution_t r;
    x = longint'($signed(start));
    count = 0;
    st = ST_CONVERGED;
    while (1) begin
      prev = x;
      x2 = q_mul(x, x);
      cx = q_mul(sq_coef, x);
      d = clamp_w(clamp_w(clamp_w(x2 + x2) + x2) + clamp_w(cx + cx));
      if (abs_w(d) < slope_min) begin
        st = ST_FLAT;
        break;
      end
      num = cubic_at(x);
      if (d == 0) begin
        // zero slope past a zero floor: saturate with the sign of f(x)
        quo = (num == 0) ? 0 : ((num < 0) ? QMIN : QMAX);
      end else begin
        quo = (abs_w(num) <<< FRAC_BITS) / abs_w(d);
        quo = clamp_w(((num < 0) != (d < 0)) ? -quo : quo);
      end
      x = clamp_w(x - quo);
      count++;
      // limit is checked before convergence, even on the last step
      if (count >= upd_limit) begin
        st = ST_LIMIT;
        break;
      end
      if (abs_w(clamp_w(x - prev)) <= tol_lim || abs_w(cubic_at(x)) <= tol_lim) begin
        st = ST_CONVERGED;
        break;
      end
    end
    r.root   = word_t'(x);
    r.iters  = count_t'(count);
    r.status = st;
    return r;
  endfunction

  function automatic word_t pick_coef();
    case ($urandom_range(9))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return word_t'($urandom);
      default: return word_t'($urandom_range(0, 32'h0800_0000)) - word_t'(32'h0400_0000);
    endcase
  endfunction

  task automatic write_reg(input cfg_idx_t idx, input word_t data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      CFG_SQUARE: sq_coef    = longint'($signed(data));
      CFG_CONST:  const_coef = longint'($signed(data));
      CFG_TOL:    tol_lim    = longint'(data[TOL_BITS-1:0]);
      CFG_LIMIT:  upd_limit  = longint'(data[LIMIT_BITS-1:0]);
      CFG_FLOOR:  slope_min  = longint'(data[TOL_BITS-1:0]);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // drop valid and drain every pending result
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_solutions.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic offer(input word_t start, input logic typed, input solution_t want);
    solution_t next_sol;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= start;
    do @(posedge clk_i); while (!s_axis_tready_o);
    next_sol = typed ? want : solve_cubic(start);
    pending_solutions = {pending_solutions, next_sol};
    if (!src_calm && $urandom_range(99) < 20) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  initial begin : result_sink
    solution_t got;
    solution_t want;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.root   = m_axis_tdata_o[31:0];
        got.iters  = m_axis_tdata_o[39:32];
        got.status = m_axis_tuser_o;
        n_results++;
        if (pending_solutions.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN)
            $display("unexpected item: root %h iters %0d status %0d",
                     got.root, got.iters, got.status);
        end else begin
          want = pending_solutions.pop_front();
          if (got.root !== want.root || got.iters !== want.iters ||
              got.status !== want.status) begin
            n_errors++;
            if (n_errors <= MAX_SHOWN)
              $display("mismatch item %0d: root %h iters %0d status %0d, want %h %0d %0d",
                       n_results, got.root, got.iters, got.status,
                       want.root, want.iters, want.status);
          end
        end
      end
      if (!held_off && n_results == 40) begin
        // hold off long enough for the block to back up into its input
        held_off = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= (n_results >= 80 && n_results < 130) || ($urandom_range(99) >= 20);
      end
    end
  end

  initial begin : stimulus
    word_t start;
    int    i;
    int    p;
    int    k;
    sq_coef    = longint'($signed(SQUARE_RESET));
    const_coef = longint'($signed(CONST_RESET));
    tol_lim    = longint'(TOL_RESET);
    upd_limit  = longint'(LIMIT_RESET);
    slope_min  = longint'(FLOOR_RESET);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].value);
      end else begin
        offer(DIR_ROWS[i].value, DIR_ROWS[i].typed, DIR_ROWS[i].want);
      end
    end

    for (p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      write_reg(CFG_SQUARE, pick_coef());
      write_reg(CFG_CONST, pick_coef());
      case ($urandom_range(5))
        0:       write_reg(CFG_TOL, '0);
        1:       write_reg(CFG_TOL, ONE);
        2:       write_reg(CFG_TOL, word_t'(17));
        default: write_reg(CFG_TOL, word_t'($urandom_range(0, 4096)));
      endcase
      case ($urandom_range(9))
        0:       write_reg(CFG_LIMIT, '0);
        1:       write_reg(CFG_LIMIT, word_t'(1));
        default: write_reg(CFG_LIMIT, word_t'($urandom_range(2, 64)));
      endcase
      case ($urandom_range(5))
        0:       write_reg(CFG_FLOOR, '0);
        1:       write_reg(CFG_FLOOR, ONE);
        default: write_reg(CFG_FLOOR, word_t'($urandom_range(1, 32'h0001_0000)));
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(9))
          0:       start = word_t'($urandom);
          1:       start = $urandom_range(1) ? WORD_MAX : WORD_MIN;
          2:       start = word_t'($urandom_range(0, 2)) - word_t'(1);
          default: start = word_t'($urandom_range(0, 32'h1000_0000)) - word_t'(32'h0800_0000);
        endcase
        src_calm = (p * PHASE_ITEMS + k >= 50) && (p * PHASE_ITEMS + k < 100);
        offer(start, 1'b0, NO_WANT);
      end
    end

    wait_idle();
    repeat (200) @(posedge clk_i);
    if (n_errors == 0 && pending_solutions.size() == 0) begin
      $display("PASS cubic_newton_root_finder_top");
    end else begin
      $display("FAIL cubic_newton_root_finder_top");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cnrf_pkg.sv
rtl/cnrf_mul.sv
rtl/cnrf_div.sv
rtl/cubic_newton_root_finder_top.sv
dv/tb_cubic_newton_root_finder_top.sv
